FILE: hdl/iocf_pkg.sv
// Package with shared types, constants and helper functions for the IPv4 option class filter.
package iocf_pkg;

   localparam int MAX_OPTION_BYTES = 40;
   localparam logic [5:0] COUNT_CAP = 6'((MAX_OPTION_BYTES < 63) ? MAX_OPTION_BYTES : 63);

   localparam logic [7:0] OPT_EOL  = 8'd0;
   localparam logic [7:0] OPT_NOP  = 8'd1;
   localparam logic [7:0] OPT_RR   = 8'd7;
   localparam logic [7:0] OPT_TS   = 8'd68;
   localparam logic [7:0] OPT_LSRR = 8'd131;
   localparam logic [7:0] OPT_SSRR = 8'd137;

   localparam logic [3:0] CLASS_PAD   = 4'b0001;
   localparam logic [3:0] CLASS_ROUTE = 4'b0010;
   localparam logic [3:0] CLASS_TS    = 4'b0100;
   localparam logic [3:0] CLASS_UNK   = 4'b1000;
   localparam logic [3:0] KEEP_ALL    = 4'b1111;

   localparam logic [1:0] KIND_RAW_LEN  = 2'd0;
   localparam logic [1:0] KIND_RAW_BYTE = 2'd1;
   localparam logic [1:0] KIND_KEPT     = 2'd2;
   localparam logic [1:0] KIND_COUNT    = 2'd3;

   localparam logic REG_KEEP_MASK = 1'b0;

   localparam int RESULT_SLOTS = 4;

   typedef enum logic [3:0] {
      PHASE_TYPE = 4'b0001,
      PHASE_LEN  = 4'b0010,
      PHASE_BODY = 4'b0100,
      PHASE_STOP = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       final_res;
   } result_type;

   typedef struct packed {
      result_type [RESULT_SLOTS-1:0] entry;
      logic [2:0]                    count;
   } bundle_type;

   function automatic logic [3:0] class_of(input logic [7:0] t);
      logic [3:0] c;
      case (t) inside
         OPT_EOL, OPT_NOP:            c = CLASS_PAD;
         OPT_RR, OPT_LSRR, OPT_SSRR:  c = CLASS_ROUTE;
         OPT_TS:                      c = CLASS_TS;
         default:                     c = CLASS_UNK;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] sat_inc(input logic [5:0] cnt);
      return (cnt < COUNT_CAP) ? cnt + 6'd1 : cnt;
   endfunction

endpackage

FILE: hdl/ipv4_option_class_filter.sv
// Top level of the IPv4 option class filter.
// The block takes one options byte per transfer and emits raw, kept-option and kept-count
// results, one result per output transfer, through the input register and then the result
// register bank. A byte that yields zero or one result lets the next byte follow in the next
// cycle unless the output stalls; a byte that yields k results (at most four) holds the input
// until the single result port drains them from the result register bank, one per unstalled
// cycle. The keep mask must only be written while no bytes are in flight.
module ipv4_option_class_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_option_byte,
   input  logic [5:0]  req_bytes_left,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic        rsp_final_res,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import iocf_pkg::*;

   logic       [3:0] keep_mask;
   logic             load_ok;
   logic             bundle_valid;
   bundle_type       bundle;

   iocf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr_index (paddr[2]),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .keep_mask   (keep_mask)
   );

   iocf_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .keep_mask       (keep_mask),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_option_byte (req_option_byte),
      .req_bytes_left  (req_bytes_left),
      .load_ok         (load_ok),
      .bundle_valid    (bundle_valid),
      .bundle          (bundle)
   );

   iocf_result_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .load          (bundle_valid),
      .bundle        (bundle),
      .load_ok       (load_ok),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_value     (rsp_value),
      .rsp_final_res (rsp_final_res)
   );

endmodule

FILE: hdl/iocf_csr.sv
// Configuration register block holding the class keep mask.
module iocf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr_index,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [3:0]  keep_mask
);
   import iocf_pkg::*;

   logic [3:0] keep_mask_ff;
   logic [3:0] keep_mask_in;
   logic       write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && (paddr_index == REG_KEEP_MASK);

   always_comb begin
      keep_mask_in = keep_mask_ff;
      if (write_en) begin
         keep_mask_in = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_mask_ff <= KEEP_ALL;
      end else begin
         keep_mask_ff <= keep_mask_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr_index == REG_KEEP_MASK) begin
         prdata = {28'd0, keep_mask_ff};
      end
   end

   assign keep_mask = keep_mask_ff;

endmodule

FILE: hdl/iocf_parser.sv
// Input register, option parse state and per-byte result bundle generation.
module iocf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          keep_mask,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_option_byte,
   input  logic [5:0]          req_bytes_left,
   input  logic                load_ok,
   output logic                bundle_valid,
   output iocf_pkg::bundle_type bundle
);
   import iocf_pkg::*;

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [5:0] left_ff, left_in;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_type_ff, held_type_in;
   logic [5:0] held_left_ff, held_left_in;
   logic [7:0] body_rem_ff, body_rem_in;
   logic       copying_ff, copying_in;
   logic [5:0] kept_ff, kept_in;
   logic       start_ff, start_in;

   logic       accept;
   logic       advance;
   logic       raw;
   logic       last;
   logic [7:0] body_dec;
   bundle_type res;

   assign advance   = stage_valid_ff && load_ok;
   assign req_stall = stage_valid_ff && !load_ok;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      byte_in        = byte_ff;
      left_in        = left_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
         byte_in        = req_option_byte;
         left_in        = req_bytes_left;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   assign raw      = (keep_mask == KEEP_ALL);
   assign last     = (left_ff == 6'd1);
   assign body_dec = (body_rem_ff != 8'd0) ? body_rem_ff - 8'd1 : body_rem_ff;

   always_comb begin
      res          = '0;
      phase_in     = phase_ff;
      held_type_in = held_type_ff;
      held_left_in = held_left_ff;
      body_rem_in  = body_rem_ff;
      copying_in   = copying_ff;
      kept_in      = kept_ff;
      start_in     = 1'b0;

      if (start_ff && raw) begin
         res.entry[res.count[1:0]] = '{KIND_RAW_LEN, {2'd0, left_ff}, 1'b0};
         res.count = res.count + 3'd1;
      end
      if (raw) begin
         res.entry[res.count[1:0]] = '{KIND_RAW_BYTE, byte_ff, 1'b0};
         res.count = res.count + 3'd1;
      end

      unique case (phase_ff)
         PHASE_TYPE: begin
            if (byte_ff == OPT_EOL || byte_ff == OPT_NOP) begin
               if ((keep_mask & CLASS_PAD) != 4'd0) begin
                  res.entry[res.count[1:0]] = '{KIND_KEPT, byte_ff, 1'b0};
                  res.count = res.count + 3'd1;
                  kept_in = sat_inc(kept_in);
               end
               if (byte_ff == OPT_EOL) begin
                  phase_in = PHASE_STOP;
               end
            end else if (last) begin
               phase_in = PHASE_STOP;
            end else begin
               held_type_in = byte_ff;
               held_left_in = left_ff;
               phase_in     = PHASE_LEN;
            end
         end
         PHASE_LEN: begin
            if (byte_ff < 8'd2 || byte_ff > {2'd0, held_left_ff}) begin
               phase_in = PHASE_STOP;
            end else begin
               copying_in = ((keep_mask & class_of(held_type_ff)) != 4'd0);
               if (copying_in) begin
                  res.entry[res.count[1:0]] = '{KIND_KEPT, held_type_ff, 1'b0};
                  res.count = res.count + 3'd1;
                  res.entry[res.count[1:0]] = '{KIND_KEPT, byte_ff, 1'b0};
                  res.count = res.count + 3'd1;
                  kept_in = sat_inc(sat_inc(kept_in));
               end
               body_rem_in = byte_ff - 8'd2;
               phase_in    = (body_rem_in != 8'd0) ? PHASE_BODY : PHASE_TYPE;
            end
         end
         PHASE_BODY: begin
            if (copying_ff) begin
               res.entry[res.count[1:0]] = '{KIND_KEPT, byte_ff, 1'b0};
               res.count = res.count + 3'd1;
               kept_in = sat_inc(kept_in);
            end
            body_rem_in = body_dec;
            if (body_dec == 8'd0) begin
               phase_in = PHASE_TYPE;
            end
         end
         PHASE_STOP: begin
         end
         default: begin
            phase_in = PHASE_STOP;
         end
      endcase

      if (last) begin
         res.entry[res.count[1:0]] = '{KIND_COUNT, {2'd0, kept_in}, 1'b1};
         res.count    = res.count + 3'd1;
         phase_in     = PHASE_TYPE;
         held_type_in = '0;
         held_left_in = '0;
         body_rem_in  = '0;
         copying_in   = 1'b0;
         kept_in      = '0;
         start_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      left_ff <= left_in;
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= PHASE_TYPE;
         held_type_ff   <= '0;
         held_left_ff   <= '0;
         body_rem_ff    <= '0;
         copying_ff     <= 1'b0;
         kept_ff        <= '0;
         start_ff       <= 1'b1;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            held_type_ff <= held_type_in;
            held_left_ff <= held_left_in;
            body_rem_ff  <= body_rem_in;
            copying_ff   <= copying_in;
            kept_ff      <= kept_in;
            start_ff     <= start_in;
         end
      end
   end

   assign bundle_valid = advance;
   assign bundle       = res;

endmodule

FILE: hdl/iocf_result_queue.sv
// Result register bank that hands out one result of a byte per output transfer.
module iocf_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  iocf_pkg::bundle_type bundle,
   output logic                 load_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_value,
   output logic                 rsp_final_res
);
   import iocf_pkg::*;

   result_type [RESULT_SLOTS-1:0] entry_ff, entry_in;
   logic [2:0] rem_ff, rem_in;
   logic [1:0] idx_ff, idx_in;
   logic       transfer;
   result_type head;

   assign rsp_valid = (rem_ff != 3'd0);
   assign transfer  = rsp_valid && !rsp_stall;
   assign load_ok   = (rem_ff == 3'd0) || (rem_ff == 3'd1 && transfer);

   always_comb begin
      entry_in = entry_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      if (load) begin
         entry_in = bundle.entry;
         rem_in   = bundle.count;
         idx_in   = '0;
      end else if (transfer) begin
         rem_in = rem_ff - 3'd1;
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         rem_ff <= '0;
         idx_ff <= '0;
      end else begin
         rem_ff <= rem_in;
         idx_ff <= idx_in;
      end
   end

   assign head          = entry_ff[idx_ff];
   assign rsp_kind      = head.kind;
   assign rsp_value     = head.value;
   assign rsp_final_res = head.final_res;

endmodule

FILE: hdl/iocf_checker.sv
// Port-level checker for the IPv4 option class filter and its bind statement.
module iocf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_value,
   input logic        rsp_final_res
);
   import iocf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
         && $stable(rsp_final_res))
      else $error("Stalled result changed or dropped.");

   a_final_is_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_res |-> rsp_kind == KIND_COUNT)
      else $error("Final flag on a result that is not the kept count.");

   a_count_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_COUNT |-> rsp_final_res)
      else $error("Kept count result without the final flag.");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_COUNT |-> rsp_value <= {2'd0, COUNT_CAP})
      else $error("Kept count beyond its saturation limit.");

endmodule

bind ipv4_option_class_filter iocf_checker u_checker (.*);
